@@ hdl/rspi_pkg.sv @@
// ----------------------------------------------------------------------------
// rspi_pkg: shared widths, codes and types for the ray/object intersect block
// Fixed-point word sizes, internal datapath widths, object kind codes and the
// structs that travel between the front queue, the math pipe and the dividers.
// ----------------------------------------------------------------------------
package rspi_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int N_VEC_WORDS = 9;

    localparam int T_W        = WORD_BITS + 1;             // origin minus center
    localparam int DIAM_W     = WORD_BITS - 1;
    localparam int DOT_W      = 2 * WORD_BITS + 4;         // dot products
    localparam int C4_W       = DOT_W + 2;                 // 4*T.T - d*d
    localparam int HALF_W     = WORD_BITS + 4;             // multiplier slice
    localparam int MAG_W      = 2 * HALF_W;                // magnitudes split in two
    localparam int SQ_W       = 2 * MAG_W;                 // wide products
    localparam int Q_W        = 2 * DOT_W - 2;             // discriminant
    localparam int X_W        = Q_W + 2 * FRAC_BITS;       // square root operand
    localparam int ROOT_W     = X_W / 2;
    localparam int NUM_W      = DOT_W + FRAC_BITS + 2;     // dividend
    localparam int DEN_W      = DOT_W;                     // divisor
    localparam int QUO_W      = WORD_BITS;
    localparam int DIV_LAT    = QUO_W + 2;

    localparam int IN_DATA_W  = ((N_VEC_WORDS * WORD_BITS + DIAM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 2 * WORD_BITS;

    localparam logic [ACT_W-1:0] ACT_SPHERE = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_PLANE  = ACT_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = CFG_IDX_W'(2);

    typedef logic [2:0][WORD_BITS-1:0] vec_t;

    typedef struct packed {
        logic                  sphere;
        logic                  plane;
        vec_t                  d;
        logic [2:0][T_W-1:0]   t;
        vec_t                  n;
        logic [DIAM_W-1:0]     diam;
    } item_t;

    typedef struct packed {
        logic                     miss;
        logic                     plane;
        logic signed [NUM_W-1:0]  base;
        logic [DEN_W-1:0]         den;
    } sq_side_t;

    typedef struct packed {
        logic miss;
        logic plane;
    } res_flags_t;

endpackage

@@ hdl/ray_sphere_plane_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_plane_intersect: ray against sphere or plane, signed Q16.16
// Streams one ray/object request in and one pair of ray parameters out.
// ----------------------------------------------------------------------------
// Usage:
//   Write the ray origin through cfg_wr_en/cfg_index/cfg_wdata while the block
//   is idle (index 0 x, 1 y, 2 z). Each s_ request carries a direction, a
//   center or plane point, a plane normal and a sphere diameter, with the
//   object kind in s_tuser. Each m_ result gives the larger root in the low
//   word of m_tdata, the smaller (or zero for a plane) in the high word, and
//   the miss flag in m_tuser; a miss returns zero roots.
//   Throughput: one request per cycle while the result side does not stall.
//   Results pass through the 83-stage square root and the 34-stage dividers.
//   Reset clears the queue, every valid bit and the origin to zero.
//   When m_tready is low with a result waiting, the whole math pipe holds;
//   the two-entry input queue keeps taking requests until it is full, then
//   drops s_tready.
// ----------------------------------------------------------------------------
module ray_sphere_plane_intersect (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // low to high: dir_x, dir_y, dir_z, center_x, center_y, center_z,
    // normal_x, normal_y, normal_z, diameter, zero pad
    input  logic [rspi_pkg::IN_DATA_W-1:0]       s_tdata,
    // action
    input  logic [rspi_pkg::ACT_W-1:0]           s_tuser,
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // low to high: root_first, root_second
    output logic [rspi_pkg::OUT_DATA_W-1:0]      m_tdata,
    // miss
    output logic                                 m_tuser,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [rspi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rspi_pkg::WORD_BITS-1:0]       cfg_wdata
);
    import rspi_pkg::*;

    vec_t    origin_reg;
    logic    back_en;
    logic    q_valid;
    item_t   q_item;

    // origin registers; unused index is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_reg[0] <= cfg_wdata;
                CFG_ORIGIN_Y: origin_reg[1] <= cfg_wdata;
                CFG_ORIGIN_Z: origin_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance the math pipe whenever the output register is free or drains
    assign back_en = !m_tvalid || m_tready;

    rspi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .origin   (origin_reg),
        .pop_en   (back_en),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    rspi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (back_en),
        .in_valid (q_valid),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // a miss never carries nonzero roots
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("miss result with nonzero roots");

    // the input queue fills only while the math pipe is held
    a_full_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !$past(back_en))
        else $error("input queue full although the pipe advanced");

endmodule

@@ hdl/rspi_front.sv @@
// ----------------------------------------------------------------------------
// rspi_front: input queue and object classification
// Splits the input request into fields, forms origin minus center, decodes the
// object kind and holds up to two classified requests for the math pipe.
// ----------------------------------------------------------------------------
module rspi_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rspi_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [rspi_pkg::ACT_W-1:0]        s_tuser,
    input  rspi_pkg::vec_t                    origin,
    input  logic                              pop_en,
    output logic                              q_valid,
    output rspi_pkg::item_t                   q_item
);
    import rspi_pkg::*;

    localparam int Q_DEPTH = 2;

    item_t      ent_reg [Q_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    item_t      item_next;
    logic       push, pop;

    always_comb begin
        item_next = '0;
        for (int j = 0; j < 3; j++) begin
            item_next.d[j] = s_tdata[j * WORD_BITS +: WORD_BITS];
            item_next.n[j] = s_tdata[(6 + j) * WORD_BITS +: WORD_BITS];
            item_next.t[j] = {origin[j][WORD_BITS-1], origin[j]}
                           - {s_tdata[(4 + j) * WORD_BITS - 1],
                              s_tdata[(3 + j) * WORD_BITS +: WORD_BITS]};
        end
        item_next.diam = s_tdata[N_VEC_WORDS * WORD_BITS +: DIAM_W];
        unique case (s_tuser)
            ACT_SPHERE: item_next.sphere = 1'b1;
            ACT_PLANE:  item_next.plane  = 1'b1;
            default: ;
        endcase
    end

    assign s_tready = (cnt_reg != 2'(Q_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = pop_en && q_valid;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_ptr_reg] <= item_next;
    end

endmodule

@@ hdl/rspi_sqrt.sv @@
// ----------------------------------------------------------------------------
// rspi_sqrt: pipelined integer square root
// One result bit per stage, most significant first; the remainder is carried
// so that every stage is a single compare and subtract.
// ----------------------------------------------------------------------------
module rspi_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [rspi_pkg::X_W-1:0]       x,
    input  rspi_pkg::sq_side_t             in_side,
    output logic                           out_valid,
    output logic [rspi_pkg::ROOT_W-1:0]    root,
    output rspi_pkg::sq_side_t             out_side
);
    import rspi_pkg::*;

    logic [ROOT_W:0]     vld_reg;
    logic [X_W-1:0]      rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]   root_reg [ROOT_W+1];
    sq_side_t            side_reg [ROOT_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ROOT_W-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= x;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;
        logic [X_W-1:0] trial;
        logic           fit;

        // trial = 2*root*2^B + 2^(2B); root has no bits at or below B yet
        assign trial = (X_W'(root_reg[k]) << (B + 1)) | (X_W'(1) << (2 * B));
        assign fit   = rem_reg[k] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= fit ? rem_reg[k] - trial : rem_reg[k];
                root_reg[k+1] <= root_reg[k] | (fit ? (ROOT_W'(1) << B) : '0);
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

@@ hdl/rspi_div.sv @@
// ----------------------------------------------------------------------------
// rspi_div: pipelined floor division with saturation
// Signed dividend over positive divisor, rounded toward minus infinity and
// clipped to the signed word range; one quotient bit per stage.
// ----------------------------------------------------------------------------
module rspi_div (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [rspi_pkg::NUM_W-1:0]     num,
    input  logic [rspi_pkg::DEN_W-1:0]            den,
    output logic signed [rspi_pkg::WORD_BITS-1:0] quo
);
    import rspi_pkg::*;

    localparam int CMP_W = DEN_W + QUO_W;
    localparam logic [WORD_BITS-1:0] SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] SAT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic               neg_reg [QUO_W+1];
    logic               ov_reg  [QUO_W+1];
    logic [NUM_W-1:0]   rem_reg [QUO_W+1];
    logic [DEN_W-1:0]   den_reg [QUO_W+1];
    logic [QUO_W-1:0]   q_reg   [QUO_W+1];
    logic [NUM_W-1:0]   m_next;
    logic               neg_next, ov_next;
    logic [QUO_W-1:0]   qf;
    logic [WORD_BITS-1:0] quo_next;
    logic [WORD_BITS-1:0] quo_reg;

    // negative dividend: floor(n/d) = -((|n| + d - 1) / d), and |n| - 1 = ~n
    always_comb begin
        neg_next = num[NUM_W-1];
        m_next   = neg_next ? (~unsigned'(num) + NUM_W'(den)) : unsigned'(num);
        ov_next  = (CMP_W'(m_next) >> QUO_W) >= CMP_W'(den);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= neg_next;
            ov_reg[0]  <= ov_next;
            rem_reg[0] <= m_next;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int B = QUO_W - 1 - k;
        logic [CMP_W-1:0] dsh;
        logic             fit;

        assign dsh = CMP_W'(den_reg[k]) << B;
        assign fit = CMP_W'(rem_reg[k]) >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[k+1] <= neg_reg[k];
                ov_reg[k+1]  <= ov_reg[k];
                den_reg[k+1] <= den_reg[k];
                rem_reg[k+1] <= fit ? rem_reg[k] - NUM_W'(dsh) : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (fit ? (QUO_W'(1) << B) : '0);
            end
        end
    end

    always_comb begin
        qf = q_reg[QUO_W];
        if (ov_reg[QUO_W]) begin
            quo_next = neg_reg[QUO_W] ? SAT_MIN : SAT_MAX;
        end else if (!neg_reg[QUO_W]) begin
            quo_next = qf[QUO_W-1] ? SAT_MAX : WORD_BITS'(qf);
        end else begin
            quo_next = (qf[QUO_W-1] && (qf[QUO_W-2:0] != '0)) ? SAT_MIN : WORD_BITS'(-qf);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) quo_reg <= quo_next;
    end

    assign quo = $signed(quo_reg);

endmodule

@@ hdl/rspi_back.sv @@
// ----------------------------------------------------------------------------
// rspi_back: intersection math pipe
// Dot products, discriminant, square root and the two floor divisions that
// turn a classified request into roots, plus the output register.
// ----------------------------------------------------------------------------
module rspi_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  rspi_pkg::item_t                    in_item,
    output logic                               m_tvalid,
    output logic                               m_tuser,
    output logic [rspi_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import rspi_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG:1] vld_reg;

    // stage 1: products
    logic signed [WORD_BITS-1:0]       v2 [3];
    logic signed [T_W+WORD_BITS-1:0]   p1_next [3], p1_reg [3];
    logic signed [2*WORD_BITS-1:0]     p2_next [3], p2_reg [3];
    logic signed [2*T_W-1:0]           p3_next [3], p3_reg [3];
    logic [2*DIAM_W-1:0]               pdm_next, pdm_reg;
    logic                              sph1_reg, pln1_reg;

    // stage 2: dot sums
    logic signed [DOT_W-1:0]  dot1_2_reg, dot2_2_reg, tt2_reg;
    logic [2*DIAM_W-1:0]      dm2_reg;
    logic                     sph2_reg, pln2_reg;

    // stage 3: c4 and plane sign fixup
    logic signed [C4_W-1:0]   c4_3_reg;
    logic signed [DOT_W-1:0]  dot1_3_reg, dot2_3_reg, pnum3_reg;
    logic [DEN_W-1:0]         pden3_reg;
    logic                     dz3_reg, sph3_reg, pln3_reg;

    // stage 4: magnitudes, dividend base and divisor
    logic [MAG_W-1:0]         habs4_reg, amag4_reg, cabs4_reg;
    logic signed [NUM_W-1:0]  base_next, base4_reg;
    logic [DEN_W-1:0]         den_next, den4_reg;
    logic                     cneg4_reg, dz4_reg, sph4_reg, pln4_reg;

    // stage 5: partial products
    logic [MAG_W-1:0]         hhh5_reg, hhl5_reg, hll5_reg;
    logic [MAG_W-1:0]         ahh5_reg, ahl5_reg, alh5_reg, all5_reg;
    logic signed [NUM_W-1:0]  base5_reg;
    logic [DEN_W-1:0]         den5_reg;
    logic                     cneg5_reg, dz5_reg, sph5_reg, pln5_reg;

    // stage 6: wide sums
    logic [SQ_W-1:0]          hsq6_reg, ac6_reg;
    logic signed [NUM_W-1:0]  base6_reg;
    logic [DEN_W-1:0]         den6_reg;
    logic                     cneg6_reg, dz6_reg, sph6_reg, pln6_reg;

    // discriminant into the root pipe
    logic signed [Q_W-1:0]    hq7, ac7, q7;
    logic                     miss7;
    logic [X_W-1:0]           x7;
    sq_side_t                 side7;

    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;
    sq_side_t                 sq_side;

    // root numerators and divider sideband
    logic signed [NUM_W-1:0]  n1_reg, n2_reg;
    logic [DEN_W-1:0]         den8_reg;
    logic [DIV_LAT:0]         fvld_reg;
    res_flags_t               fl_reg [DIV_LAT+1];
    logic signed [WORD_BITS-1:0] quo1, quo2;

    logic [WORD_BITS-1:0]     res2_next;
    logic [OUT_DATA_W-1:0]    tdata_next;
    logic                     m_tvalid_reg, m_tuser_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            v2[j]      = in_item.sphere ? $signed(in_item.d[j]) : $signed(in_item.n[j]);
            p1_next[j] = $signed(in_item.t[j]) * v2[j];
            p2_next[j] = $signed(in_item.d[j]) * v2[j];
            p3_next[j] = $signed(in_item.t[j]) * $signed(in_item.t[j]);
        end
        pdm_next = in_item.diam * in_item.diam;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-1:1], in_valid};
        end
    end

    always_comb begin
        base_next = pln3_reg ? (NUM_W'(pnum3_reg) <<< FRAC_BITS)
                             : -(NUM_W'(dot1_3_reg) <<< (FRAC_BITS + 1));
        den_next  = pln3_reg ? pden3_reg : (DEN_W'(dot2_3_reg) << 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
            pdm_reg  <= pdm_next;
            sph1_reg <= in_item.sphere;
            pln1_reg <= in_item.plane;

            dot1_2_reg <= DOT_W'(p1_reg[0]) + DOT_W'(p1_reg[1]) + DOT_W'(p1_reg[2]);
            dot2_2_reg <= DOT_W'(p2_reg[0]) + DOT_W'(p2_reg[1]) + DOT_W'(p2_reg[2]);
            tt2_reg    <= DOT_W'(p3_reg[0]) + DOT_W'(p3_reg[1]) + DOT_W'(p3_reg[2]);
            dm2_reg    <= pdm_reg;
            sph2_reg   <= sph1_reg;
            pln2_reg   <= pln1_reg;

            c4_3_reg   <= (C4_W'(tt2_reg) <<< 2) - $signed(C4_W'(dm2_reg));
            dot1_3_reg <= dot1_2_reg;
            dot2_3_reg <= dot2_2_reg;
            pnum3_reg  <= dot2_2_reg[DOT_W-1] ? dot1_2_reg : -dot1_2_reg;
            pden3_reg  <= DEN_W'(dot2_2_reg[DOT_W-1] ? -dot2_2_reg : dot2_2_reg);
            dz3_reg    <= (dot2_2_reg == '0);
            sph3_reg   <= sph2_reg;
            pln3_reg   <= pln2_reg;

            habs4_reg  <= MAG_W'(dot1_3_reg[DOT_W-1] ? -dot1_3_reg : dot1_3_reg);
            amag4_reg  <= MAG_W'(dot2_3_reg);
            cabs4_reg  <= MAG_W'(c4_3_reg[C4_W-1] ? -c4_3_reg : c4_3_reg);
            cneg4_reg  <= c4_3_reg[C4_W-1];
            base4_reg  <= base_next;
            den4_reg   <= den_next;
            dz4_reg    <= dz3_reg;
            sph4_reg   <= sph3_reg;
            pln4_reg   <= pln3_reg;

            hhh5_reg  <= habs4_reg[MAG_W-1:HALF_W] * habs4_reg[MAG_W-1:HALF_W];
            hhl5_reg  <= habs4_reg[MAG_W-1:HALF_W] * habs4_reg[HALF_W-1:0];
            hll5_reg  <= habs4_reg[HALF_W-1:0] * habs4_reg[HALF_W-1:0];
            ahh5_reg  <= amag4_reg[MAG_W-1:HALF_W] * cabs4_reg[MAG_W-1:HALF_W];
            ahl5_reg  <= amag4_reg[MAG_W-1:HALF_W] * cabs4_reg[HALF_W-1:0];
            alh5_reg  <= amag4_reg[HALF_W-1:0] * cabs4_reg[MAG_W-1:HALF_W];
            all5_reg  <= amag4_reg[HALF_W-1:0] * cabs4_reg[HALF_W-1:0];
            base5_reg <= base4_reg;
            den5_reg  <= den4_reg;
            cneg5_reg <= cneg4_reg;
            dz5_reg   <= dz4_reg;
            sph5_reg  <= sph4_reg;
            pln5_reg  <= pln4_reg;

            hsq6_reg  <= (SQ_W'(hhh5_reg) << MAG_W) + (SQ_W'(hhl5_reg) << (HALF_W + 1))
                       + SQ_W'(hll5_reg);
            ac6_reg   <= (SQ_W'(ahh5_reg) << MAG_W)
                       + ((SQ_W'(ahl5_reg) + SQ_W'(alh5_reg)) << HALF_W)
                       + SQ_W'(all5_reg);
            base6_reg <= base5_reg;
            den6_reg  <= den5_reg;
            cneg6_reg <= cneg5_reg;
            dz6_reg   <= dz5_reg;
            sph6_reg  <= sph5_reg;
            pln6_reg  <= pln5_reg;
        end
    end

    // Q = 4*H*H - A*C4, with the sign of C4 folded into add or subtract
    always_comb begin
        hq7   = $signed(Q_W'(hsq6_reg << 2));
        ac7   = $signed(Q_W'(ac6_reg));
        q7    = cneg6_reg ? hq7 + ac7 : hq7 - ac7;
        miss7 = !(sph6_reg || pln6_reg) || dz6_reg || (sph6_reg && q7[Q_W-1]);
        x7    = (sph6_reg && !miss7) ? (X_W'(unsigned'(q7)) << (2 * FRAC_BITS)) : '0;
        side7.miss  = miss7;
        side7.plane = pln6_reg;
        side7.base  = base6_reg;
        side7.den   = den6_reg;
    end

    rspi_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[NSTG]),
        .x         (x7),
        .in_side   (side7),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvld_reg <= '0;
        end else if (en) begin
            fvld_reg <= {fvld_reg[DIV_LAT-1:0], sq_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg    <= sq_side.base + $signed(NUM_W'(sq_root));
            n2_reg    <= sq_side.base - $signed(NUM_W'(sq_root));
            den8_reg  <= sq_side.den;
            fl_reg[0] <= '{miss: sq_side.miss, plane: sq_side.plane};
            for (int k = 0; k < DIV_LAT; k++) begin
                fl_reg[k+1] <= fl_reg[k];
            end
        end
    end

    rspi_div u_div_first (
        .aclk (aclk),
        .en   (en),
        .num  (n1_reg),
        .den  (den8_reg),
        .quo  (quo1)
    );

    rspi_div u_div_second (
        .aclk (aclk),
        .en   (en),
        .num  (n2_reg),
        .den  (den8_reg),
        .quo  (quo2)
    );

    always_comb begin
        res2_next  = fl_reg[DIV_LAT].plane ? '0 : unsigned'(quo2);
        tdata_next = fl_reg[DIV_LAT].miss ? '0 : {res2_next, unsigned'(quo1)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fvld_reg[DIV_LAT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tuser_reg <= fl_reg[DIV_LAT].miss;
            m_tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ verif/ray_sphere_plane_intersect_test.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_plane_intersect_test: self-checking bench for the intersect block
// Drives ray/object requests in bursts against a stalling result side and
// checks every result against its typed value or a wide-integer predictor of
// the sphere and plane math, over several ray origins, range extremes included.
// ----------------------------------------------------------------------------
module ray_sphere_plane_intersect_test;
    import rspi_pkg::*;

    localparam int DRAIN_WAIT = 150;   // a bit over the block's pipe latency
    localparam int LONG_HOLD  = 400;   // receiver hold-off, longer than the pipe

    typedef logic signed [255:0] wide_t;

    // one ray/object request
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        vec_t              dir;
        vec_t              cen;
        vec_t              nrm;
        logic [DIAM_W-1:0] diam;
    } ray_req_t;

    // one intersection result
    typedef struct packed {
        logic                 miss;
        logic [WORD_BITS-1:0] t_far;
        logic [WORD_BITS-1:0] t_near;
    } hit_t;

    // directed row: a request and, where it is obvious, its typed result
    typedef struct packed {
        ray_req_t req;
        logic     typed;
        hit_t     hit;
    } row_t;

    localparam logic [ACT_W-1:0] ACT_CYL  = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_BAD  = ACT_W'(3);
    localparam logic [31:0] W_MAX = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE   = 32'h0001_0000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [ACT_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_BITS-1:0] cfg_wdata = '0;

    // predictor copy of the origin registers
    vec_t org;
    hit_t hit_q[$];
    int   err_cnt = 0;
    bit   hold_req = 0;
    int   hold_left = 0;
    int   rx_mode = 0;
    int   rx_cnt = 0;
    row_t rows[$];

    ray_sphere_plane_intersect uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    initial begin
        #(4 * 2_000_000);
        $display("ray_sphere_plane_intersect_test NOT OK");
        $finish;
    end

    function automatic wide_t sx(logic [31:0] v);
        wide_t r;
        r = $signed(v);
        return r;
    endfunction

    function automatic wide_t dot3(wide_t a0, wide_t a1, wide_t a2,
                                   wide_t b0, wide_t b1, wide_t b2);
        return a0 * b0 + a1 * b1 + a2 * b2;
    endfunction

    // floor division, divisor positive
    function automatic wide_t div_floor(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (n < 0 && q * d != n) q = q - 1;
        return q;
    endfunction

    function automatic wide_t isqrt(wide_t x);
        wide_t r, c;
        r = 0;
        for (int i = 100; i >= 0; i--) begin
            c = r | (wide_t'(1) <<< i);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_word(wide_t v);
        if (v > sx(W_MAX)) return W_MAX;
        if (v < sx(W_MIN)) return W_MIN;
        return v[31:0];
    endfunction

    // work out the intersection of one request against the current origin
    function automatic hit_t predict_hit(ray_req_t rq);
        hit_t h;
        wide_t d[3], n[3], t[3];
        wide_t a, hh, c4, q, s, base, den, num, dm;
        h = '{miss: 1'b1, t_far: '0, t_near: '0};
        for (int i = 0; i < 3; i++) begin
            d[i] = sx(rq.dir[i]);
            n[i] = sx(rq.nrm[i]);
            t[i] = sx(org[i]) - sx(rq.cen[i]);
        end
        if (rq.act == ACT_SPHERE) begin
            dm = {225'd0, rq.diam};
            a  = dot3(d[0], d[1], d[2], d[0], d[1], d[2]);
            hh = dot3(t[0], t[1], t[2], d[0], d[1], d[2]);
            c4 = 4 * dot3(t[0], t[1], t[2], t[0], t[1], t[2]) - dm * dm;
            q  = 4 * hh * hh - a * c4;
            if (a != 0 && q >= 0) begin
                s    = isqrt(q <<< (2 * FRAC_BITS));
                base = -(hh <<< (FRAC_BITS + 1));
                den  = a <<< 1;
                h.t_far  = clamp_word(div_floor(base + s, den));
                h.t_near = clamp_word(div_floor(base - s, den));
                h.miss = 1'b0;
            end
        end else if (rq.act == ACT_PLANE) begin
            num = -dot3(n[0], n[1], n[2], t[0], t[1], t[2]);
            den = dot3(d[0], d[1], d[2], n[0], n[1], n[2]);
            if (den != 0) begin
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                h.t_far = clamp_word(div_floor(num <<< FRAC_BITS, den));
                h.miss = 1'b0;
            end
        end
        return h;
    endfunction

    function automatic ray_req_t mk_req(logic [ACT_W-1:0] act, vec_t dir, vec_t cen,
                                        vec_t nrm, logic [DIAM_W-1:0] diam);
        ray_req_t r;
        r.act = act; r.dir = dir; r.cen = cen; r.nrm = nrm; r.diam = diam;
        return r;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 9))
            0: return W_MAX;
            1: return W_MIN;
            2: return '0;
            3, 4: return $urandom;
            default: return $urandom_range(0, 20 << 16) - (10 << 16);
        endcase
    endfunction

    function automatic ray_req_t rnd_req();
        ray_req_t r;
        int k;
        k = $urandom_range(0, 99);
        r.act = (k < 45) ? ACT_SPHERE : (k < 85) ? ACT_PLANE : ACT_W'($urandom_range(2, 3));
        if ($urandom_range(0, 9) == 0) r.act = ACT_W'($urandom);
        for (int i = 0; i < 3; i++) begin
            r.dir[i] = rnd_word();
            r.cen[i] = rnd_word();
            r.nrm[i] = rnd_word();
        end
        case ($urandom_range(0, 5))
            0: r.diam = DIAM_W'($urandom);
            1: r.diam = '1;
            2: r.diam = '0;
            default: r.diam = DIAM_W'($urandom_range(0, 30 << 16));
        endcase
        return r;
    endfunction

    // offer one request, hold until it is taken, record its expectation
    task automatic send_req(ray_req_t rq, logic typed, hit_t th);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = rq.act;
        s_tdata  = IN_DATA_W'({rq.diam, rq.nrm, rq.cen, rq.dir});
        do @(posedge aclk); while (!s_tready);
        hit_q.push_back(typed ? th : predict_hit(rq));
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // wait for every outstanding result, then let the pipe empty
    task automatic drain();
        idle_for(1);
        while (hit_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_origin(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vec_t v;
        v = {z, y, x};
        for (int i = 0; i < 3; i++) begin
            @(negedge aclk);
            cfg_wr_en = 1'b1;
            cfg_index = (i == 0) ? CFG_ORIGIN_X : (i == 1) ? CFG_ORIGIN_Y : CFG_ORIGIN_Z;
            cfg_wdata = v[i];
        end
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        org = v;
    endtask

    task automatic run_random(int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_req(rnd_req(), 1'b0, '0);
                left--;
            end
            if ($urandom_range(0, 9) < 7) idle_for($urandom_range(1, 6));
        end
    endtask

    // result checker: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (hit_q.size() == 0) begin
                $error("unexpected result miss=%0b data=%h", m_tuser, m_tdata);
                err_cnt++;
            end else begin
                e = hit_q.pop_front();
                if (m_tuser !== e.miss) begin
                    $error("miss: expected %0b, got %0b", e.miss, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[31:0] !== e.t_far) begin
                    $error("root_first: expected %h, got %h", e.t_far, m_tdata[31:0]);
                    err_cnt++;
                end
                if (m_tdata[63:32] !== e.t_near) begin
                    $error("root_second: expected %h, got %h", e.t_near, m_tdata[63:32]);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: stall pattern whose mode is redrawn periodically, plus a long hold
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 0;
        end
        rx_cnt++;
        if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 3) != 0);
                default: m_tready = ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    initial begin
        vec_t z0, ex, ey, ez, mx, mn;
        z0 = '0;
        ex = {32'd0, 32'd0, ONE};
        ey = {32'd0, ONE, 32'd0};
        ez = {ONE, 32'd0, 32'd0};
        mx = {W_MAX, W_MAX, W_MAX};
        mn = {W_MIN, W_MIN, W_MIN};
        org = '0;

        // zero direction against a sphere: miss
        rows.push_back('{mk_req(ACT_SPHERE, z0, z0, z0, '0), 1'b1, '{1'b1, '0, '0}});
        // unit sphere hit along x: center 5, diameter 2, roots 6 and 4
        rows.push_back('{mk_req(ACT_SPHERE, ex, {32'd0, 32'd0, 32'd5 << 16}, z0, 2 << 16),
                         1'b1, '{1'b0, 32'd6 << 16, 32'd4 << 16}});
        // negative discriminant: ray along y misses a sphere at x = 10
        rows.push_back('{mk_req(ACT_SPHERE, ey, {32'd0, 32'd0, 32'd10 << 16}, z0, 2 << 16),
                         1'b1, '{1'b1, '0, '0}});
        // plane z = 3 hit along z at t = 3
        rows.push_back('{mk_req(ACT_PLANE, ez, {32'd3 << 16, 32'd0, 32'd0}, ez, '0),
                         1'b1, '{1'b0, 32'd3 << 16, '0}});
        // plane parallel to the ray: zero denominator
        rows.push_back('{mk_req(ACT_PLANE, ex, ez, ez, '0), 1'b1, '{1'b1, '0, '0}});
        // unknown kinds
        rows.push_back('{mk_req(ACT_CYL, ex, ex, ez, 2 << 16), 1'b1, '{1'b1, '0, '0}});
        rows.push_back('{mk_req(ACT_BAD, mx, mn, mx, '1), 1'b1, '{1'b1, '0, '0}});
        // plane overflow: tiny denominator, far plane saturates high
        rows.push_back('{mk_req(ACT_PLANE, {32'd1, 32'd0, 32'd0}, {W_MAX, 32'd0, 32'd0},
                         {32'd1, 32'd0, 32'd0}, '0), 1'b1, '{1'b0, W_MAX, '0}});
        // ... and saturates low with the plane point moved to the negative end
        rows.push_back('{mk_req(ACT_PLANE, {32'd1, 32'd0, 32'd0}, {W_MIN, 32'd0, 32'd0},
                         {32'd1, 32'd0, 32'd0}, '0), 1'b1, '{1'b0, W_MIN, '0}});
        // extremes, left to the predictor
        rows.push_back('{mk_req(ACT_SPHERE, mx, mx, mx, '1), 1'b0, '0});
        rows.push_back('{mk_req(ACT_SPHERE, mn, mx, mn, '1), 1'b0, '0});
        rows.push_back('{mk_req(ACT_SPHERE, {32'd0, 32'd0, 32'd1}, mn, z0, '1), 1'b0, '0});
        rows.push_back('{mk_req(ACT_SPHERE, mx, z0, z0, '0), 1'b0, '0});
        rows.push_back('{mk_req(ACT_SPHERE, ey, z0, z0, 4 << 16), 1'b0, '0});
        rows.push_back('{mk_req(ACT_PLANE, mx, mn, mx, '1), 1'b0, '0});
        rows.push_back('{mk_req(ACT_PLANE, mn, mx, mx, '0), 1'b0, '0});
        rows.push_back('{mk_req(ACT_PLANE, {32'd0, 32'd0, 32'h0000_8000}, mn, ex, '0),
                         1'b0, '0});
        rows.push_back('{mk_req(ACT_PLANE, {ONE, ONE, W_MIN}, {ONE, 32'd7, 32'hffff_0000},
                         mn, '0), 1'b0, '0});

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].hit);
        drain();

        // long receiver hold while requests keep coming
        hold_req = 1;
        run_random(250);
        drain();

        set_origin(W_MAX, W_MIN, 32'd0);
        run_random(250);
        drain();
        set_origin(W_MIN, W_MAX, $urandom);
        run_random(250);
        drain();
        set_origin($urandom_range(0, 20 << 16) - (10 << 16),
                   $urandom_range(0, 20 << 16) - (10 << 16),
                   $urandom_range(0, 20 << 16) - (10 << 16));
        run_random(250);
        drain();
        set_origin($urandom, $urandom, $urandom);
        run_random(250);
        drain();
        set_origin(32'd0, 32'd0, 32'd0);
        run_random(250);
        drain();

        if (err_cnt == 0 && hit_q.size() == 0) begin
            $display("ray_sphere_plane_intersect_test OK");
        end else begin
            $display("ray_sphere_plane_intersect_test NOT OK");
        end
        $finish;
    end
endmodule

@@ ray_sphere_plane_intersect.f @@
hdl/rspi_pkg.sv
hdl/rspi_front.sv
hdl/rspi_sqrt.sv
hdl/rspi_div.sv
hdl/rspi_back.sv
hdl/ray_sphere_plane_intersect.sv
verif/ray_sphere_plane_intersect_test.sv
